[src/cpe_pkg.sv]
// ----------------------------------------------------------------------------
// cpe_pkg
// shared codes and the queue item type of the citation score engine
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

    localparam int ART_FIELD_W = 12;
    localparam int CNT_FIELD_W = 15;
    localparam int SCORE_W     = 32;

    localparam logic [SCORE_W-1:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NONCONTIG = 2'd3;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_REJECT = 2'd3;

    localparam logic [1:0] CFG_ARTICLE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_ITERATION_COUNT = 2'd1;
    localparam logic [1:0] CFG_BASE_TERM       = 2'd2;
    localparam logic [1:0] CFG_DAMPING         = 2'd3;

    typedef struct packed {
        logic [1:0]             op;
        logic [ART_FIELD_W-1:0] article;
        logic [ART_FIELD_W-1:0] citer;
    } item_t;

endpackage

`default_nettype wire

[src/citation_pagerank_engine_core.sv]
// ----------------------------------------------------------------------------
// citation_pagerank_engine_core
// citation graph loader and in-place fixed-point ranking engine
// ----------------------------------------------------------------------------
// items enter on the s_ channel (load edge, run passes, read score) and each
// gives exactly one result on the m_ channel; cfg_we writes one register
// a two-entry queue sits between the classifying front and the executing back
// load edge: write the cited article and store the edge unless its citations
// are not contiguous or the edge store is full, then update the citer; read:
// register the article's score and counts; reject: bad index or unknown
// command; run: per pass every article slot is read, and each stored citation
// of an active article goes through the single read port of the stores and
// the divider that yields one quotient bit per cycle; one item is carried out
// at a time; up to two more wait in the queue; after reset the article store
// is swept clear with s_ready low; configuration writes are taken meanwhile
// a stalled receiver holds the result in the output register; the back then
// waits and the front keeps taking items until the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module citation_pagerank_engine_core #(
    parameter int MAX_ARTICLES = 4096,
    parameter int MAX_EDGES    = 16384
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [20:0]                         cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_cmd,
    input  wire logic [cpe_pkg::ART_FIELD_W-1:0]     s_article,
    input  wire logic [cpe_pkg::ART_FIELD_W-1:0]     s_citing_article,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cpe_pkg::SCORE_W-1:0]              m_score,
    output logic [cpe_pkg::CNT_FIELD_W-1:0]          m_in_edges,
    output logic [cpe_pkg::CNT_FIELD_W-1:0]          m_out_edges,
    output logic [1:0]                               m_status
);

    localparam int LIM_W = $clog2(MAX_ARTICLES + 1);

    logic [12:0]      art_cnt_reg;
    logic [7:0]       iter_reg;
    logic [20:0]      base_reg;
    logic [16:0]      damp_reg;
    logic [31:0]      lim32;
    logic [LIM_W-1:0] lim;
    logic             clearing;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    cpe_pkg::item_t   push_item;
    cpe_pkg::item_t   pop_item;

    assign lim32 = (32'(art_cnt_reg) > 32'(MAX_ARTICLES)) ? 32'(MAX_ARTICLES)
                                                            : 32'(art_cnt_reg);
    assign lim   = lim32[LIM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            art_cnt_reg <= 13'd4096;
            iter_reg    <= 8'd10;
            base_reg    <= 21'd9830;
            damp_reg    <= 17'd55706;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cpe_pkg::CFG_ARTICLE_COUNT:   art_cnt_reg <= cfg_wdata[12:0];
                cpe_pkg::CFG_ITERATION_COUNT: iter_reg    <= cfg_wdata[7:0];
                cpe_pkg::CFG_BASE_TERM:       base_reg    <= cfg_wdata;
                cpe_pkg::CFG_DAMPING:         damp_reg    <= cfg_wdata[16:0];
                default: begin
                end
            endcase
        end
    end

    cpe_front #(
        .LIM_W(LIM_W)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_article       (s_article),
        .s_citing_article(s_citing_article),
        .lim             (lim),
        .clearing        (clearing),
        .q_full          (q_full),
        .push            (push),
        .push_item       (push_item)
    );

    cpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .full     (q_full),
        .pop      (pop),
        .pop_item (pop_item),
        .empty    (q_empty)
    );

    cpe_back #(
        .MAX_ARTICLES(MAX_ARTICLES),
        .MAX_EDGES   (MAX_EDGES),
        .LIM_W       (LIM_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .lim            (lim),
        .iteration_count(iter_reg),
        .base_term      (base_reg),
        .damping        (damp_reg),
        .clearing       (clearing),
        .q_empty        (q_empty),
        .q_item         (pop_item),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_score        (m_score),
        .m_in_edges     (m_in_edges),
        .m_out_edges    (m_out_edges),
        .m_status       (m_status)
    );

endmodule

`default_nettype wire

[src/cpe_front.sv]
// ----------------------------------------------------------------------------
// cpe_front
// accepts items and classifies them by command and index range
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_front #(
    parameter int LIM_W = 13
) (
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_cmd,
    input  wire logic [cpe_pkg::ART_FIELD_W-1:0] s_article,
    input  wire logic [cpe_pkg::ART_FIELD_W-1:0] s_citing_article,
    input  wire logic [LIM_W-1:0]                lim,
    input  wire logic                            clearing,
    input  wire logic                            q_full,
    output logic                                 push,
    output cpe_pkg::item_t                       push_item
);

    logic [31:0] lim32;
    logic [31:0] art32;
    logic [31:0] cit32;
    logic        art_ok;
    logic        cit_ok;

    assign lim32  = 32'(lim);
    assign art32  = 32'(s_article);
    assign cit32  = 32'(s_citing_article);
    assign art_ok = art32 < lim32;
    assign cit_ok = cit32 < lim32;

    assign s_ready = !q_full && !clearing;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_item.article = s_article;
        push_item.citer   = s_citing_article;
        unique case (s_cmd)
            cpe_pkg::CMD_LOAD: begin
                push_item.op = (art_ok && cit_ok) ? cpe_pkg::OP_LOAD : cpe_pkg::OP_REJECT;
            end
            cpe_pkg::CMD_RUN: begin
                push_item.op = cpe_pkg::OP_RUN;
            end
            cpe_pkg::CMD_READ: begin
                push_item.op = art_ok ? cpe_pkg::OP_READ : cpe_pkg::OP_REJECT;
            end
            default: begin
                push_item.op = cpe_pkg::OP_REJECT;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/cpe_queue.sv]
// ----------------------------------------------------------------------------
// cpe_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  cpe_pkg::item_t      push_item,
    output logic                full,
    input  wire logic           pop,
    output cpe_pkg::item_t      pop_item,
    output logic                empty
);

    cpe_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[src/cpe_div.sv]
// ----------------------------------------------------------------------------
// cpe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_div #(
    parameter int DIV_W = 15
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cpe_pkg::SCORE_W-1:0]   dividend,
    input  wire logic [DIV_W-1:0]              divisor,
    output logic                               done,
    output logic [cpe_pkg::SCORE_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(cpe_pkg::SCORE_W + 1);

    logic [cpe_pkg::SCORE_W-1:0] quo_reg;
    logic [cpe_pkg::SCORE_W-1:0] quo_next;
    logic [DIV_W-1:0]            rem_reg;
    logic [DIV_W-1:0]            rem_next;
    logic [DIV_W-1:0]            dvs_reg;
    logic [DIV_W-1:0]            dvs_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic [DIV_W:0]              sh;
    logic [DIV_W:0]              diff;

    assign sh       = {rem_reg, quo_reg[cpe_pkg::SCORE_W-1]};
    assign diff     = sh - {1'b0, dvs_reg};
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(cpe_pkg::SCORE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (sh >= {1'b0, dvs_reg}) begin
                    rem_next = diff[DIV_W-1:0];
                    quo_next = {quo_reg[cpe_pkg::SCORE_W-2:0], 1'b1};
                end else begin
                    rem_next = sh[DIV_W-1:0];
                    quo_next = {quo_reg[cpe_pkg::SCORE_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

[src/cpe_back.sv]
// ----------------------------------------------------------------------------
// cpe_back
// carries out loads, reads and ranking passes on the article and edge stores
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_back #(
    parameter int MAX_ARTICLES = 4096,
    parameter int MAX_EDGES    = 16384,
    parameter int LIM_W        = 13
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [LIM_W-1:0]                lim,
    input  wire logic [7:0]                      iteration_count,
    input  wire logic [20:0]                     base_term,
    input  wire logic [16:0]                     damping,
    output logic                                 clearing,
    input  wire logic                            q_empty,
    input  cpe_pkg::item_t                       q_item,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [cpe_pkg::SCORE_W-1:0]          m_score,
    output logic [cpe_pkg::CNT_FIELD_W-1:0]      m_in_edges,
    output logic [cpe_pkg::CNT_FIELD_W-1:0]      m_out_edges,
    output logic [1:0]                           m_status
);

    localparam int ART_AW  = $clog2(MAX_ARTICLES);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FILL_W  = $clog2(MAX_EDGES + 1);
    localparam int SUM_W   = cpe_pkg::SCORE_W + FILL_W;
    localparam int LO_W    = SUM_W / 2;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int P0_W    = 17 + LO_W;
    localparam int P1_W    = 17 + HI_W;
    localparam int PROD_W  = 17 + SUM_W + 1;
    localparam int SW      = cpe_pkg::SCORE_W;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_LD0   = 5'd2;
    localparam logic [4:0] S_LD1   = 5'd3;
    localparam logic [4:0] S_LD2   = 5'd4;
    localparam logic [4:0] S_LD3   = 5'd5;
    localparam logic [4:0] S_RD0   = 5'd6;
    localparam logic [4:0] S_RD1   = 5'd7;
    localparam logic [4:0] S_RA0   = 5'd8;
    localparam logic [4:0] S_RA1   = 5'd9;
    localparam logic [4:0] S_RE0   = 5'd10;
    localparam logic [4:0] S_RE1   = 5'd11;
    localparam logic [4:0] S_RE2   = 5'd12;
    localparam logic [4:0] S_RDIV  = 5'd13;
    localparam logic [4:0] S_RM0   = 5'd14;
    localparam logic [4:0] S_RM1   = 5'd15;
    localparam logic [4:0] S_RM2   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    // article store
    logic [SW-1:0]      score_mem  [MAX_ARTICLES];
    logic               act_mem    [MAX_ARTICLES];
    logic [FILL_W-1:0]  odeg_mem   [MAX_ARTICLES];
    logic [FILL_W-1:0]  icnt_mem   [MAX_ARTICLES];
    logic [EDGE_AW-1:0] istart_mem [MAX_ARTICLES];
    // edge store
    logic [cpe_pkg::ART_FIELD_W-1:0] citer_mem [MAX_EDGES];

    logic [SW-1:0]      rd_score_reg;
    logic               rd_act_reg;
    logic [FILL_W-1:0]  rd_odeg_reg;
    logic [FILL_W-1:0]  rd_icnt_reg;
    logic [EDGE_AW-1:0] rd_istart_reg;
    logic [cpe_pkg::ART_FIELD_W-1:0] rd_citer_reg;

    logic [ART_AW-1:0]  art_ra;
    logic               art_we;
    logic [ART_AW-1:0]  art_wa;
    logic [SW-1:0]      w_score;
    logic               w_act;
    logic [FILL_W-1:0]  w_odeg;
    logic [FILL_W-1:0]  w_icnt;
    logic [EDGE_AW-1:0] w_istart;
    logic [EDGE_AW-1:0] edge_ra;
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_wa;
    logic [cpe_pkg::ART_FIELD_W-1:0] edge_wd;

    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic [ART_AW-1:0]  clr_reg;
    logic [ART_AW-1:0]  clr_next;
    cpe_pkg::item_t     item_reg;
    cpe_pkg::item_t     item_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [cpe_pkg::ART_FIELD_W-1:0] grp_reg;
    logic [cpe_pkg::ART_FIELD_W-1:0] grp_next;
    logic               grp_open_reg;
    logic               grp_open_next;
    logic [7:0]         pass_reg;
    logic [7:0]         pass_next;
    logic [LIM_W-1:0]   a_reg;
    logic [LIM_W-1:0]   a_next;
    logic [FILL_W-1:0]  k_reg;
    logic [FILL_W-1:0]  k_next;
    logic [EDGE_AW-1:0] start_reg;
    logic [EDGE_AW-1:0] start_next;
    logic [FILL_W-1:0]  count_reg;
    logic [FILL_W-1:0]  count_next;
    logic [FILL_W-1:0]  a_odeg_reg;
    logic [FILL_W-1:0]  a_odeg_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [P0_W-1:0]    p0_reg;
    logic [P0_W-1:0]    p0_next;
    logic [P1_W-1:0]    p1_reg;
    logic [P1_W-1:0]    p1_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [SW-1:0]      m_score_reg;
    logic [SW-1:0]      m_score_next;
    logic [cpe_pkg::CNT_FIELD_W-1:0] m_in_reg;
    logic [cpe_pkg::CNT_FIELD_W-1:0] m_in_next;
    logic [cpe_pkg::CNT_FIELD_W-1:0] m_out_reg;
    logic [cpe_pkg::CNT_FIELD_W-1:0] m_out_next;
    logic [1:0]         m_status_reg;
    logic [1:0]         m_status_next;

    logic               div_start;
    logic               div_done;
    logic [SW-1:0]      div_quo;

    logic [31:0]        art32;
    logic [31:0]        cit32;
    logic [31:0]        a32;
    logic [31:0]        rc32;
    logic [31:0]        e32;
    logic [31:0]        fill32;
    logic [31:0]        icnt32;
    logic [31:0]        odeg32;
    logic               same_grp;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  val;
    logic [SW-1:0]      val_sat;

    cpe_div #(
        .DIV_W(FILL_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(rd_score_reg),
        .divisor (rd_odeg_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign art32    = 32'(item_reg.article);
    assign cit32    = 32'(item_reg.citer);
    assign a32      = 32'(a_reg);
    assign rc32     = 32'(rd_citer_reg);
    assign e32      = 32'(start_reg) + 32'(k_reg);
    assign fill32   = 32'(fill_reg);
    assign icnt32   = 32'(rd_icnt_reg);
    assign odeg32   = 32'(rd_odeg_reg);
    assign same_grp = grp_open_reg && (grp_reg == item_reg.article);

    assign prod    = (PROD_W'(p1_reg) << LO_W) + PROD_W'(p0_reg);
    assign val     = PROD_W'(base_term) + (prod >> 16);
    assign val_sat = (val[PROD_W-1:SW] != '0) ? {SW{1'b1}} : val[SW-1:0];

    assign clearing    = state_reg == S_CLEAR;
    assign m_valid     = m_valid_reg;
    assign m_score     = m_score_reg;
    assign m_in_edges  = m_in_reg;
    assign m_out_edges = m_out_reg;
    assign m_status    = m_status_reg;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        item_next     = item_reg;
        fill_next     = fill_reg;
        grp_next      = grp_reg;
        grp_open_next = grp_open_reg;
        pass_next     = pass_reg;
        a_next        = a_reg;
        k_next        = k_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        a_odeg_next   = a_odeg_reg;
        sum_next      = sum_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        m_valid_next  = m_valid_reg;
        m_score_next  = m_score_reg;
        m_in_next     = m_in_reg;
        m_out_next    = m_out_reg;
        m_status_next = m_status_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        art_ra        = art32[ART_AW-1:0];
        art_we        = 1'b0;
        art_wa        = art32[ART_AW-1:0];
        w_score       = rd_score_reg;
        w_act         = rd_act_reg;
        w_odeg        = rd_odeg_reg;
        w_icnt        = rd_icnt_reg;
        w_istart      = rd_istart_reg;
        edge_ra       = e32[EDGE_AW-1:0];
        edge_we       = 1'b0;
        edge_wa       = fill32[EDGE_AW-1:0];
        edge_wd       = item_reg.citer;

        unique case (state_reg)
            S_CLEAR: begin
                art_we   = 1'b1;
                art_wa   = clr_reg;
                w_score  = '0;
                w_act    = 1'b0;
                w_odeg   = '0;
                w_icnt   = '0;
                w_istart = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(MAX_ARTICLES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop         = 1'b1;
                    item_next     = q_item;
                    m_score_next  = '0;
                    m_in_next     = '0;
                    m_out_next    = '0;
                    m_status_next = cpe_pkg::ST_OK;
                    unique case (q_item.op)
                        cpe_pkg::OP_LOAD: state_next = S_LD0;
                        cpe_pkg::OP_READ: state_next = S_RD0;
                        cpe_pkg::OP_RUN: begin
                            pass_next = '0;
                            a_next    = '0;
                            if (iteration_count == 8'd0) begin
                                m_valid_next = 1'b1;
                                state_next   = S_OUT;
                            end else begin
                                state_next = S_RA0;
                            end
                        end
                        default: begin
                            m_status_next = cpe_pkg::ST_RANGE;
                            m_valid_next  = 1'b1;
                            state_next    = S_OUT;
                        end
                    endcase
                end
            end
            S_LD0: begin
                state_next = S_LD1;
            end
            S_LD1: begin
                if (!same_grp && (rd_icnt_reg != '0)) begin
                    m_status_next = cpe_pkg::ST_NONCONTIG;
                    m_valid_next  = 1'b1;
                    state_next    = S_OUT;
                end else if (fill32 >= 32'(MAX_EDGES)) begin
                    m_status_next = cpe_pkg::ST_FULL;
                    m_valid_next  = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    art_we        = 1'b1;
                    w_score       = cpe_pkg::ONE_Q16;
                    w_act         = 1'b1;
                    w_icnt        = rd_icnt_reg + 1'b1;
                    w_istart      = same_grp ? rd_istart_reg : fill32[EDGE_AW-1:0];
                    edge_we       = 1'b1;
                    fill_next     = fill_reg + 1'b1;
                    grp_next      = item_reg.article;
                    grp_open_next = 1'b1;
                    state_next    = S_LD2;
                end
            end
            S_LD2: begin
                art_ra     = cit32[ART_AW-1:0];
                state_next = S_LD3;
            end
            S_LD3: begin
                art_we       = 1'b1;
                art_wa       = cit32[ART_AW-1:0];
                w_score      = cpe_pkg::ONE_Q16;
                w_act        = 1'b1;
                w_odeg       = rd_odeg_reg + 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_RD0: begin
                state_next = S_RD1;
            end
            S_RD1: begin
                m_score_next = rd_score_reg;
                m_in_next    = icnt32[cpe_pkg::CNT_FIELD_W-1:0];
                m_out_next   = odeg32[cpe_pkg::CNT_FIELD_W-1:0];
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_RA0: begin
                art_ra = a32[ART_AW-1:0];
                if (a_reg == lim) begin
                    a_next = '0;
                    if (pass_reg + 8'd1 == iteration_count) begin
                        m_valid_next = 1'b1;
                        state_next   = S_OUT;
                    end else begin
                        pass_next = pass_reg + 8'd1;
                    end
                end else begin
                    state_next = S_RA1;
                end
            end
            S_RA1: begin
                if (!rd_act_reg) begin
                    a_next     = a_reg + 1'b1;
                    state_next = S_RA0;
                end else begin
                    start_next  = rd_istart_reg;
                    count_next  = rd_icnt_reg;
                    a_odeg_next = rd_odeg_reg;
                    k_next      = '0;
                    sum_next    = '0;
                    state_next  = S_RE0;
                end
            end
            S_RE0: begin
                if (k_reg == count_reg) begin
                    state_next = S_RM0;
                end else begin
                    state_next = S_RE1;
                end
            end
            S_RE1: begin
                art_ra     = rc32[ART_AW-1:0];
                state_next = S_RE2;
            end
            S_RE2: begin
                if (rd_odeg_reg == '0) begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RE0;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_RDIV;
                end
            end
            S_RDIV: begin
                if (div_done) begin
                    sum_next   = sum_reg + SUM_W'(div_quo);
                    k_next     = k_reg + 1'b1;
                    state_next = S_RE0;
                end
            end
            S_RM0: begin
                p0_next    = P0_W'(damping) * P0_W'(sum_reg[LO_W-1:0]);
                state_next = S_RM1;
            end
            S_RM1: begin
                p1_next    = P1_W'(damping) * P1_W'(sum_reg[SUM_W-1:LO_W]);
                state_next = S_RM2;
            end
            S_RM2: begin
                art_we     = 1'b1;
                art_wa     = a32[ART_AW-1:0];
                w_score    = val_sat;
                w_act      = 1'b1;
                w_odeg     = a_odeg_reg;
                w_icnt     = count_reg;
                w_istart   = start_reg;
                a_next     = a_reg + 1'b1;
                state_next = S_RA0;
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            fill_reg     <= '0;
            grp_open_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            fill_reg     <= fill_next;
            grp_open_reg <= grp_open_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        grp_reg      <= grp_next;
        pass_reg     <= pass_next;
        a_reg        <= a_next;
        k_reg        <= k_next;
        start_reg    <= start_next;
        count_reg    <= count_next;
        a_odeg_reg   <= a_odeg_next;
        sum_reg      <= sum_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        m_score_reg  <= m_score_next;
        m_in_reg     <= m_in_next;
        m_out_reg    <= m_out_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (art_we) begin
            score_mem[art_wa]  <= w_score;
            act_mem[art_wa]    <= w_act;
            odeg_mem[art_wa]   <= w_odeg;
            icnt_mem[art_wa]   <= w_icnt;
            istart_mem[art_wa] <= w_istart;
        end
        rd_score_reg  <= score_mem[art_ra];
        rd_act_reg    <= act_mem[art_ra];
        rd_odeg_reg   <= odeg_mem[art_ra];
        rd_icnt_reg   <= icnt_mem[art_ra];
        rd_istart_reg <= istart_mem[art_ra];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            citer_mem[edge_wa] <= edge_wd;
        end
        rd_citer_reg <= citer_mem[edge_ra];
    end

endmodule

`default_nettype wire
